/* rtl/core/first_fit_page_allocator_top_assert.svh */
// Assertion macros for the first-fit page allocator.
// Expects signals clk and arst_n in the including module.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ffpa_pkg.sv */
// Shared types and constants of the first-fit page allocator.
// No dependencies.
`default_nettype none

package ffpa_pkg;

	localparam int FIELD_W  = 48;   // width of size/offset fields on the ports
	localparam int BLK_W    = 21;   // block size register width
	localparam int WIDE_W   = 64;   // widest internal address width
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_REUSED    = 3'd0,
		ST_NEW       = 3'd1,
		ST_STORED    = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_EXHAUSTED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ROUND,
		S_SCAN,
		S_SHIFT,
		S_NEWPG,
		S_EMIT
	} fsm_t;

endpackage

`default_nettype wire

/* rtl/core/ffpa_if.sv */
// Request and response channel interfaces of the page allocator.
// Depends on ffpa_pkg.
`default_nettype none

interface ffpa_req_if;
	logic                           valid;
	logic                           ready;
	ffpa_pkg::opcode_t              opcode;
	logic [ffpa_pkg::FIELD_W-1:0]   req_size;
	logic [ffpa_pkg::FIELD_W-1:0]   req_offset;

	modport source (output valid, output opcode, output req_size, output req_offset,
		input ready);
	modport sink (input valid, input opcode, input req_size, input req_offset,
		output ready);
endinterface

interface ffpa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ffpa_pkg::FIELD_W-1:0]   page_offset;
	logic [ffpa_pkg::FIELD_W-1:0]   page_size;
	ffpa_pkg::status_t              status;

	modport source (output valid, output page_offset, output page_size, output status,
		input ready);
	modport sink (input valid, input page_offset, input page_size, input status,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/first_fit_page_allocator_top.sv */
// First-fit page allocator: free list in one synchronous RAM, bit-serial rounding divider.
// Depends on ffpa_pkg, ffpa_if.sv and first_fit_page_allocator_top_assert.svh.
//
//   channel | dir | transaction
//   req     | in  | opcode, req_size, req_offset
//   rsp     | out | page_offset, page_size, status
//   cfg     | in  | cfg_we, cfg_idx, cfg_wdata (write only)
//
// Free: accept, then result into the output register.
// Alloc: restoring remainder (one size bit a cycle), a rounding step, a walk over the
//   free-list entries, a move down of each entry after a hit, then end-pointer check
//   and result.
// The walk and compaction are bound by the single read and write port of the list RAM.
// No clearing pass after reset; a finished result waits in the output register and
// the next transaction is taken meanwhile; rsp stalls hold the block in its last step.
`default_nettype none

module first_fit_page_allocator_top #(
	parameter int LIST_DEPTH = 32,
	parameter int ADDR_BITS  = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ffpa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [ffpa_pkg::FIELD_W-1:0]  cfg_wdata,
	ffpa_req_if.sink                           req,
	ffpa_rsp_if.source                         rsp
);
	import ffpa_pkg::*;

	localparam int AW   = ADDR_BITS;
	localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW   = $clog2(LIST_DEPTH + 1);
	localparam int SUMW = ((AW > BLK_W) ? AW : BLK_W) + 1;
	localparam int EW   = 2 * AW;

	// state and control
	fsm_t                  state_q, state_d;
	logic [BLK_W-1:0]      blk_q;
	logic [AW-1:0]         end_q, end_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [CW-1:0]         idx_q, idx_d;
	logic [DIV_CNT_W-1:0]  bit_q, bit_d;
	logic                  ovalid_q;

	// payload
	logic [AW-1:0]         size_q, size_d;
	logic [AW-1:0]         need_q, need_d;
	logic [FIELD_W-1:0]    dvd_q, dvd_d;
	logic [BLK_W-1:0]      rem_q, rem_d;
	logic [AW-1:0]         res_off_q, res_off_d;
	logic [AW-1:0]         res_size_q, res_size_d;
	status_t               res_st_q, res_st_d;
	logic [FIELD_W-1:0]    out_off_q, out_size_q;
	status_t               out_st_q;

	// list RAM
	logic [EW-1:0]         mem [LIST_DEPTH];
	logic [EW-1:0]         rd_data_q;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr, mem_raddr;
	logic [EW-1:0]         mem_wdata;

	// datapath helpers
	logic                  accept, load_out;
	logic [WIDE_W-1:0]     size_wide, off_wide, size_in_wide, cfg_wide;
	logic [AW-1:0]         size_in, off_in, cfg_off;
	logic [BLK_W-1:0]      blk_eff;
	logic [BLK_W:0]        div_t, div_diff;
	logic [BLK_W-1:0]      add_amt;
	logic [SUMW-1:0]       round_sum;
	logic                  round_exh;
	logic [AW:0]           end_sum;
	logic [AW-1:0]         ent_size, ent_off;
	logic                  hit, more;
	logic [CW-1:0]         nxt;
	logic [CW-1:0]         idx_m1;
	logic [WIDE_W-1:0]     res_off_wide, res_size_wide;
	logic                  scan_hit, free_push;

	assign size_wide    = WIDE_W'(req.req_size);
	assign off_wide     = WIDE_W'(req.req_offset);
	assign size_in      = size_wide[AW-1:0];
	assign off_in       = off_wide[AW-1:0];
	assign size_in_wide = WIDE_W'(size_in);
	assign cfg_wide     = WIDE_W'(cfg_wdata);
	assign cfg_off      = cfg_wide[AW-1:0];

	assign blk_eff  = (blk_q == '0) ? BLK_W'(1) : blk_q;
	assign div_t    = {rem_q, dvd_q[FIELD_W-1]};
	assign div_diff = div_t - {1'b0, blk_eff};

	assign add_amt   = blk_eff - rem_q;
	assign round_sum = SUMW'(size_q) + SUMW'(add_amt);
	assign round_exh = (rem_q != '0) && (round_sum[SUMW-1:AW] != '0);

	assign end_sum = {1'b0, end_q} + {1'b0, need_q};

	assign ent_size = rd_data_q[EW-1:AW];
	assign ent_off  = rd_data_q[AW-1:0];
	assign hit      = (ent_size >= need_q);
	assign nxt      = idx_q + CW'(1);
	assign more     = (nxt < cnt_q);
	assign idx_m1   = idx_q - CW'(1);

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == S_EMIT) && (!ovalid_q || rsp.ready);

	assign scan_hit  = (state_q == S_SCAN) && hit;
	assign free_push = accept && (req.opcode == OP_FREE) && (cnt_q < CW'(LIST_DEPTH));

	assign res_off_wide  = WIDE_W'(res_off_q);
	assign res_size_wide = WIDE_W'(res_size_q);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = ovalid_q;
	assign rsp.page_offset = out_off_q;
	assign rsp.page_size   = out_size_q;
	assign rsp.status      = out_st_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (req.opcode == OP_ALLOC) ? S_DIV : S_EMIT;
				end
			end
			S_DIV: begin
				if (bit_q == '0) begin
					state_d = S_ROUND;
				end
			end
			S_ROUND: begin
				if (round_exh) begin
					state_d = S_EMIT;
				end else if (cnt_q == '0) begin
					state_d = S_NEWPG;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = more ? S_SHIFT : S_EMIT;
				end else if (!more) begin
					state_d = S_NEWPG;
				end
			end
			S_SHIFT: begin
				if (idx_q == cnt_q) begin
					state_d = S_EMIT;
				end
			end
			S_NEWPG: state_d = S_EMIT;
			S_EMIT: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and RAM control
	always_comb begin
		end_d      = end_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		bit_d      = bit_q;
		size_d     = size_q;
		need_d     = need_q;
		dvd_d      = dvd_q;
		rem_d      = rem_q;
		res_off_d  = res_off_q;
		res_size_d = res_size_q;
		res_st_d   = res_st_q;
		mem_we     = 1'b0;
		mem_waddr  = cnt_q[IW-1:0];
		mem_wdata  = {size_in, off_in};
		mem_raddr  = '0;
		if (nxt < CW'(LIST_DEPTH)) begin
			mem_raddr = nxt[IW-1:0];
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_off_d  = '0;
					res_size_d = '0;
					if (req.opcode == OP_ALLOC) begin
						size_d = size_in;
						dvd_d  = size_in_wide[FIELD_W-1:0];
						rem_d  = '0;
						bit_d  = DIV_CNT_W'(FIELD_W - 1);
					end else if (cnt_q < CW'(LIST_DEPTH)) begin
						mem_we   = 1'b1;
						cnt_d    = cnt_q + CW'(1);
						res_st_d = ST_STORED;
					end else begin
						res_st_d = ST_DROPPED;
					end
				end
			end
			S_DIV: begin
				// restoring remainder, one dividend bit per cycle
				dvd_d = {dvd_q[FIELD_W-2:0], 1'b0};
				rem_d = div_diff[BLK_W] ? div_t[BLK_W-1:0] : div_diff[BLK_W-1:0];
				bit_d = bit_q - DIV_CNT_W'(1);
			end
			S_ROUND: begin
				mem_raddr = '0;
				idx_d     = '0;
				need_d    = (rem_q == '0) ? size_q : round_sum[AW-1:0];
				if (round_exh) begin
					res_st_d = ST_EXHAUSTED;
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_off_d  = ent_off;
					res_size_d = ent_size;
					res_st_d   = ST_REUSED;
					cnt_d      = cnt_q - CW'(1);
				end
				idx_d = nxt;
			end
			S_SHIFT: begin
				// close the gap: entry idx moves to idx-1
				mem_we    = 1'b1;
				mem_waddr = idx_m1[IW-1:0];
				mem_wdata = rd_data_q;
				idx_d     = nxt;
			end
			S_NEWPG: begin
				if (end_sum[AW]) begin
					res_st_d = ST_EXHAUSTED;
				end else begin
					res_off_d  = end_q;
					res_size_d = need_q;
					res_st_d   = ST_NEW;
					end_d      = end_sum[AW-1:0];
				end
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
		// start offset write reloads the end pointer
		if (cfg_we && (cfg_idx == CFG_START_OFFSET)) begin
			end_d = cfg_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			blk_q    <= BLK_W'(1);
			end_q    <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			bit_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			bit_q   <= bit_d;
			end_q   <= end_d;
			if (cfg_we && (cfg_idx == CFG_BLOCK_SIZE)) begin
				blk_q <= cfg_wdata[BLK_W-1:0];
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		size_q     <= size_d;
		need_q     <= need_d;
		dvd_q      <= dvd_d;
		rem_q      <= rem_d;
		res_off_q  <= res_off_d;
		res_size_q <= res_size_d;
		res_st_q   <= res_st_d;
		if (load_out) begin
			out_off_q  <= res_off_wide[FIELD_W-1:0];
			out_size_q <= res_size_wide[FIELD_W-1:0];
			out_st_q   <= res_st_q;
		end
	end

	// free-list RAM, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

`include "first_fit_page_allocator_top_assert.svh"

	`FFPA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(LIST_DEPTH), "free count above depth")
	`FFPA_ASSERT_NEXT(a_hit_pops, scan_hit, cnt_q == $past(cnt_q) - CW'(1), "hit kept entry")
	`FFPA_ASSERT_NEXT(a_free_push, free_push, cnt_q == $past(cnt_q) + CW'(1), "free not stored")
	`FFPA_ASSERT_NEXT(a_end_hold, (state_q != S_NEWPG) && !cfg_we, $stable(end_q), "end moved")

endmodule

`default_nettype wire

/* dv/first_fit_page_allocator_top_tb.sv */
// Self-checking testbench for first_fit_page_allocator_top: directed table, then random traffic.
// Depends on ffpa_pkg and the ffpa_req_if / ffpa_rsp_if channel interfaces.
module first_fit_page_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ffpa_pkg::*;

	localparam int CLK_PERIOD = 2;
	localparam int LIST_DEPTH = 32;
	localparam int TOTAL_REQS = 920;
	localparam int TIMEOUT_NS = 1_500_000;
	localparam bit [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam bit [63:0] ADDR_MAX = 64'h0000_FFFF_FFFF_FFFF;

	typedef struct packed {
		bit [47:0] page_offset;
		bit [47:0] page_size;
		status_t   status;
	} page_rsp_t;

	typedef struct {
		bit [47:0] len;
		bit [47:0] base;
	} free_page_t;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		opcode_t                  op;
		logic [CFG_IDX_W-1:0]     cfg_reg;
		bit [47:0]                arg_size;   // request size, or register value
		bit [47:0]                arg_off;
		bit                       typed;      // expected result given in the row
		page_rsp_t                want;
	} dir_row_t;

	localparam page_rsp_t NO_WANT = '{48'd0, 48'd0, ST_REUSED};

	// After reset: block size 1, end pointer 0, empty free list.
	dir_row_t directed_rows [27] = '{
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd0, 48'd0, 1'b1, '{48'd0, 48'd0, ST_NEW}},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd5, 48'd0, 1'b1, '{48'd0, 48'd5, ST_NEW}},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, MAX48, 48'h123, 1'b1, '{48'd0, 48'd0, ST_EXHAUSTED}},
		'{ROW_REQ, OP_FREE, CFG_BLOCK_SIZE, 48'd16, 48'h100, 1'b1, '{48'd0, 48'd0, ST_STORED}},
		'{ROW_REQ, OP_FREE, CFG_BLOCK_SIZE, 48'd8, 48'h200, 1'b1, '{48'd0, 48'd0, ST_STORED}},
		'{ROW_REQ, OP_FREE, CFG_BLOCK_SIZE, MAX48, MAX48, 1'b1, '{48'd0, 48'd0, ST_STORED}},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd10, 48'd0, 1'b1, '{48'h100, 48'd16, ST_REUSED}},
		// zero size takes the oldest entry whatever its size
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd0, 48'd0, 1'b1, '{48'h200, 48'd8, ST_REUSED}},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, MAX48, MAX48, 1'b1, '{MAX48, MAX48, ST_REUSED}},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd7, 48'd0, 1'b1, '{48'd5, 48'd7, ST_NEW}},
		'{ROW_CFG, OP_ALLOC, CFG_BLOCK_SIZE, 48'd4096, 48'd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd1, 48'd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_FREE, CFG_BLOCK_SIZE, 48'd100, 48'h5000, 1'b0, NO_WANT},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd100, 48'd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd0, 48'd0, 1'b0, NO_WANT},
		'{ROW_CFG, OP_ALLOC, CFG_BLOCK_SIZE, 48'd0, 48'd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd3, 48'd0, 1'b0, NO_WANT},
		'{ROW_CFG, OP_ALLOC, CFG_BLOCK_SIZE, 48'h1F_FFFF, 48'd0, 1'b0, NO_WANT},
		// rounding itself overflows the address space
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, MAX48 - 48'd1, 48'd0, 1'b1,
			'{48'd0, 48'd0, ST_EXHAUSTED}},
		'{ROW_CFG, OP_ALLOC, CFG_START_OFFSET, MAX48 - 48'd10, 48'd0, 1'b0, NO_WANT},
		'{ROW_CFG, OP_ALLOC, CFG_BLOCK_SIZE, 48'd1, 48'd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd10, 48'd0, 1'b1, '{MAX48 - 48'd10, 48'd10, ST_NEW}},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd0, 48'd0, 1'b1, '{MAX48, 48'd0, ST_NEW}},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd1, 48'd0, 1'b1, '{48'd0, 48'd0, ST_EXHAUSTED}},
		'{ROW_CFG, OP_ALLOC, CFG_START_OFFSET, 48'd0, 48'd0, 1'b0, NO_WANT},
		'{ROW_CFG, OP_ALLOC, CFG_BLOCK_SIZE, 48'd1048576, 48'd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_ALLOC, CFG_BLOCK_SIZE, 48'd1, 48'd0, 1'b1, '{48'd0, 48'd1048576, ST_NEW}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [FIELD_W-1:0]   cfg_wdata;

	ffpa_req_if req_ch();
	ffpa_rsp_if rsp_ch();

	first_fit_page_allocator_top #(
		.LIST_DEPTH(LIST_DEPTH),
		.ADDR_BITS (48)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// allocator shadow state
	bit [20:0]   block_sz;
	bit [47:0]   end_ptr;
	free_page_t  free_pages[$];

	page_rsp_t   pending_grants[$];
	free_page_t  held_pages[$];      // granted pages that random traffic may free again
	bit          no_idle;
	int          rsp_hold_cycles;
	int          reqs_sent;
	int          results_seen;
	int          mismatch_count;
	int          reg_writes;
	int          status_count [5];

	function automatic bit [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic int idle_cycles();
		if (no_idle)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic bit round_to_block(input bit [47:0] len, output bit [63:0] need);
		bit [63:0] unit;
		bit [63:0] rem;
		bit [63:0] add;
		unit = (block_sz == 0) ? 64'd1 : 64'(block_sz);
		rem = 64'(len) % unit;
		if (rem == 0) begin
			need = 64'(len);
			return 1'b1;
		end
		add = unit - rem;
		if (64'(len) > ADDR_MAX - add)
			return 1'b0;
		need = 64'(len) + add;
		return 1'b1;
	endfunction

	function automatic page_rsp_t predict_page(opcode_t op, bit [47:0] len, bit [47:0] base);
		page_rsp_t r;
		bit [63:0] need;
		r.page_offset = '0;
		r.page_size = '0;
		if (op == OP_FREE) begin
			if (free_pages.size() >= LIST_DEPTH) begin
				r.status = ST_DROPPED;
			end else begin
				free_pages.push_back('{len, base});
				r.status = ST_STORED;
			end
			return r;
		end
		r.status = ST_EXHAUSTED;
		if (!round_to_block(len, need))
			return r;
		foreach (free_pages[i]) begin
			if (free_pages[i].len >= need) begin
				r.page_offset = free_pages[i].base;
				r.page_size = free_pages[i].len;
				r.status = ST_REUSED;
				free_pages.delete(i);
				return r;
			end
		end
		if (64'(end_ptr) > ADDR_MAX - need)
			return r;
		r.page_offset = end_ptr;
		r.page_size = need[47:0];
		r.status = ST_NEW;
		end_ptr = end_ptr + need[47:0];
		return r;
	endfunction

	function automatic bit [47:0] alloc_len();
		int unsigned unit;
		unit = (block_sz == 0) ? 1 : int'(block_sz);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return rand48();
			2: return 48'(unit * $urandom_range(1, 4));
			default: return 48'($urandom_range(0, 3 * unit));
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
		mismatch_count++;
		$display("[%0t] %s: got 0x%h, want 0x%h (result %0d)",
			$realtime, what, got, want, results_seen);
	endtask

	task automatic send_req(opcode_t op, bit [47:0] len, bit [47:0] base, bit typed,
			page_rsp_t want);
		page_rsp_t pred;
		int gap;
		// in-order single sender, so predicting at offer time equals predicting at accept
		pred = predict_page(op, len, base);
		pending_grants.push_back(typed ? want : pred);
		status_count[pred.status]++;
		if (pred.status == ST_REUSED || pred.status == ST_NEW) begin
			held_pages.push_back('{pred.page_size, pred.page_offset});
			if (held_pages.size() > 64)
				void'(held_pages.pop_front());
		end
		gap = idle_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.req_size <= len;
		req_ch.req_offset <= base;
		do @(posedge clk); while (!req_ch.ready);
		reqs_sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [47:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BLOCK_SIZE)
			block_sz = val[BLK_W-1:0];
		else
			end_ptr = val;
		reg_writes++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_BLOCK_SIZE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ALLOC;
		req_ch.req_size = '0;
		req_ch.req_offset = '0;
		rsp_ch.ready = 1'b0;
		block_sz = 21'd1;
		end_ptr = '0;
		no_idle = 1'b0;
		rsp_hold_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : stimulus
		int episode;
		int pick;
		int k;
		int n;
		bit [47:0] val;
		free_page_t pg;
		episode = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_reg(directed_rows[i].cfg_reg, directed_rows[i].arg_size);
			else
				send_req(directed_rows[i].op, directed_rows[i].arg_size,
					directed_rows[i].arg_off, directed_rows[i].typed, directed_rows[i].want);
		end

		while (reqs_sent < TOTAL_REQS) begin
			episode++;
			if (episode % 8 == 0) begin
				case ($urandom_range(0, 7))
					0: val = '0;
					1: val = 48'd1;
					2: val = 48'd1 << $urandom_range(0, 20);
					3: val = 48'h1F_FFFF;
					4: val = 48'($urandom_range(1, 1048576));
					default: val = 48'($urandom_range(1, 64));
				endcase
				// bits above the register width must be ignored
				if ($urandom_range(0, 3) == 0)
					val[47:21] = 27'($urandom);
				write_reg(CFG_BLOCK_SIZE, val);
				if ($urandom_range(0, 1) == 1) begin
					case ($urandom_range(0, 3))
						0: val = '0;
						1: val = 48'($urandom_range(0, 1 << 20));
						2: val = MAX48 - 48'($urandom_range(0, 1 << 16));
						default: val = rand48();
					endcase
					write_reg(CFG_START_OFFSET, val);
				end
			end
			no_idle = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 9);
			if (episode % 25 == 3) begin
				// output held off while requests keep coming: input must back up
				no_idle = 1'b1;
				rsp_hold_cycles = $urandom_range(300, 600);
				repeat (24) begin
					if ($urandom_range(0, 1) == 1)
						send_req(OP_FREE, alloc_len(), rand48(), 1'b0, NO_WANT);
					else
						send_req(OP_ALLOC, alloc_len(), rand48(), 1'b0, NO_WANT);
				end
			end else if (pick < 6) begin
				// allocate, and hand back pages that were granted earlier
				n = $urandom_range(20, 40);
				repeat (n) begin
					if (held_pages.size() > 0 && $urandom_range(0, 2) == 0) begin
						k = $urandom_range(0, held_pages.size() - 1);
						pg = held_pages[k];
						held_pages.delete(k);
						send_req(OP_FREE, pg.len, pg.base, 1'b0, NO_WANT);
					end else begin
						send_req(OP_ALLOC, alloc_len(), rand48(), 1'b0, NO_WANT);
					end
				end
			end else if (pick < 8) begin
				// overfill the free list, then pull some entries back out
				repeat ($urandom_range(34, 40))
					send_req(OP_FREE, alloc_len(), rand48(), 1'b0, NO_WANT);
				repeat (8)
					send_req(OP_ALLOC, alloc_len(), rand48(), 1'b0, NO_WANT);
			end else begin
				repeat ($urandom_range(10, 20))
					send_req(opcode_t'($urandom_range(0, 1)), rand48(), rand48(), 1'b0,
						NO_WANT);
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("Sent %0d requests: %0d reused, %0d new, %0d stored, %0d dropped, %0d exhausted.",
			reqs_sent, status_count[ST_REUSED], status_count[ST_NEW], status_count[ST_STORED],
			status_count[ST_DROPPED], status_count[ST_EXHAUSTED]);
		$display("%0d register writes, %0d results checked, %0d mismatches.",
			reg_writes, results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : rsp_side
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
			end
			stall = idle_cycles();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : result_check
		page_rsp_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("result with no transaction pending", rsp_ch.page_offset, '0);
			end else begin
				want = pending_grants.pop_front();
				if (rsp_ch.page_offset !== want.page_offset)
					report_mismatch("page_offset", rsp_ch.page_offset, want.page_offset);
				if (rsp_ch.page_size !== want.page_size)
					report_mismatch("page_size", rsp_ch.page_size, want.page_size);
				if (rsp_ch.status !== want.status)
					report_mismatch("status", 48'(rsp_ch.status), 48'(want.status));
				results_seen++;
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timeout: %0d requests sent, %0d results still pending.",
			reqs_sent, pending_grants.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
